### rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// Bounded sequence deque package
// Shared constants, request and result types, and control codes.
// ----------------------------------------------------------------------------
package bsd_pkg;

    // Storage geometry.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths of the request and result.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int OCNT_W  = 5;
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Operation codes carried by a request.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_TAKE_FRONT = 3'd2,
        OP_TAKE_BACK  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REV_ALL    = 3'd5,
        OP_REV_RANGE  = 3'd6,
        OP_CLEAR      = 3'd7
    } mode_t;

    // Completion status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // What each cell loads in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } cell_op_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_REV  = 1'b1
    } ctrl_state_t;

    // One request.
    typedef struct packed {
        mode_t                     mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          range_first;
        logic [POS_W-1:0]          range_last;
    } req_t;

    // One result.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        status_t                   status;
        logic [OCNT_W-1:0]         count;
    } rsp_t;

    // Control handed from the controller to the row of cells.
    typedef struct packed {
        cell_op_t [CAPACITY-1:0] op;
        logic [DATA_WIDTH-1:0]   load_data;
    } cell_bus_t;

endpackage

### rtl/bsd_cell.sv
// ----------------------------------------------------------------------------
// Bounded sequence deque cell
// Holds one element and takes a new one from its left or right neighbor,
// from the shared load bus, or keeps its own.
// ----------------------------------------------------------------------------
module bsd_cell
    import bsd_pkg::*;
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [DATA_WIDTH-1:0] left_d,
    input  logic [DATA_WIDTH-1:0] right_d,
    input  logic [DATA_WIDTH-1:0] load_d,
    output logic [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Select the next element for this position.
    always_comb
    begin
        case (op)
            CELL_LOAD:  data_next = load_d;
            CELL_LEFT:  data_next = left_d;
            CELL_RIGHT: data_next = right_d;
            default:    data_next = data_reg;
        endcase
    end

    // Element register; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### rtl/bsd_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded sequence deque controller
// Decodes requests, keeps the element count, steers the row of cells and
// registers the result.
// ----------------------------------------------------------------------------
module bsd_ctrl
    import bsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  req_t                  request,
    input  logic [DATA_WIDTH-1:0] cell_q [CAPACITY],
    output cell_bus_t             cell_bus,
    output logic                  busy,
    output logic                  result_valid,
    output rsp_t                  result
);

    ctrl_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [IDX_W-1:0]      hi_reg, hi_next;
    logic                  valid_reg, valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  step_en;
    logic                  pop_shift;
    logic [IDX_W-1:0]      step_lo;
    logic [IDX_W-1:0]      step_hi;
    logic [DATA_WIDTH-1:0] load_data;
    logic [IDX_W-1:0]      read_idx;
    logic [DATA_WIDTH-1:0] read_data;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      first_ext;
    logic [CMP_W-1:0]      last_ext;
    logic [CMP_W-1:0]      count_ext;
    logic [IDX_W-1:0]      ins_idx;
    logic                  range_ok;

    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_ext   = CMP_W'(request.position);
    assign first_ext = CMP_W'(request.range_first);
    assign last_ext  = CMP_W'(request.range_last);
    assign count_ext = CMP_W'(count_reg);
    assign ins_idx   = (pos_ext > count_ext) ? IDX_W'(count_reg) : IDX_W'(request.position);
    assign range_ok  = (first_ext >= CMP_W'(1)) && (first_ext < last_ext)
                       && (last_ext <= count_ext);

    // One shared read port: the back element on a back pop, the range end on a swap.
    assign read_idx  = (state_reg == ST_REV) ? hi_reg : IDX_W'(count_reg - 1'b1);
    assign read_data = cell_q[read_idx];

    // Next state, count, step window and result.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        valid_next = 1'b0;
        rsp_next   = rsp_reg;
        step_en    = 1'b0;
        pop_shift  = 1'b0;
        step_lo    = '0;
        step_hi    = IDX_W'(CAPACITY - 1);
        load_data  = DATA_WIDTH'(request.value);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    valid_next         = 1'b1;
                    rsp_next.value_res = '0;
                    rsp_next.status    = STAT_OK;
                    case (request.mode)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                step_en    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                step_en    = 1'b1;
                                step_lo    = IDX_W'(count_reg);
                                step_hi    = IDX_W'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_TAKE_FRONT:
                        begin
                            if (empty)
                            begin
                                rsp_next.value_res = '1;
                                rsp_next.status    = STAT_EMPTY;
                            end
                            else
                            begin
                                rsp_next.value_res = VALUE_W'($signed(cell_q[0]));
                                pop_shift          = 1'b1;
                                count_next         = count_reg - 1'b1;
                            end
                        end
                        OP_TAKE_BACK:
                        begin
                            if (empty)
                            begin
                                rsp_next.value_res = '1;
                                rsp_next.status    = STAT_EMPTY;
                            end
                            else
                            begin
                                rsp_next.value_res = VALUE_W'($signed(read_data));
                                count_next         = count_reg - 1'b1;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                step_en    = 1'b1;
                                step_lo    = ins_idx;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REV_ALL:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                valid_next = 1'b0;
                                state_next = ST_REV;
                                lo_next    = '0;
                                hi_next    = IDX_W'(count_reg - 1'b1);
                            end
                        end
                        OP_REV_RANGE:
                        begin
                            if (!range_ok)
                            begin
                                rsp_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                state_next = ST_REV;
                                lo_next    = IDX_W'(request.range_first - 1'b1);
                                hi_next    = IDX_W'(request.range_last - 1'b1);
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                    rsp_next.count = OCNT_W'(count_next);
                end
            end
            ST_REV:
            begin
                // Move the range end to the low edge and shift the rest up.
                step_en   = 1'b1;
                step_lo   = lo_reg;
                step_hi   = hi_reg;
                load_data = read_data;
                lo_next   = lo_reg + 1'b1;
                if (lo_reg + 1'b1 == hi_reg)
                begin
                    state_next         = ST_IDLE;
                    valid_next         = 1'b1;
                    rsp_next.value_res = '0;
                    rsp_next.status    = STAT_OK;
                    rsp_next.count     = OCNT_W'(count_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Per-cell steering from the step window or the front pop.
    always_comb
    begin
        cell_bus.load_data = load_data;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_bus.op[i] = CELL_HOLD;
            if (pop_shift)
            begin
                if (i < CAPACITY - 1)
                begin
                    cell_bus.op[i] = CELL_RIGHT;
                end
            end
            else if (step_en)
            begin
                if (IDX_W'(i) == step_lo)
                begin
                    cell_bus.op[i] = CELL_LOAD;
                end
                else if ((IDX_W'(i) > step_lo) && (IDX_W'(i) <= step_hi))
                begin
                    cell_bus.op[i] = CELL_LEFT;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = rsp_reg;

    // The count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // A swap pass always has a nonempty window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV) |-> (lo_reg < hi_reg))
        else $error("reverse window collapsed");

    // No result is shown while a reversal is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV) |-> !valid_reg)
        else $error("result during reversal");

    // Requests other than reversals answer on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.mode != OP_REV_ALL && request.mode != OP_REV_RANGE)
        |=> valid_reg)
        else $error("missing result for single-cycle request");

    // The count moves only when a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a request");

endmodule

### rtl/bounded_sequence_deque.sv
// ----------------------------------------------------------------------------
// Bounded sequence deque
// Ordered store of up to CAPACITY signed elements with push, pop, insert,
// reverse and clear, built as a row of element cells in logical order.
// ----------------------------------------------------------------------------
// Usage:
// A request (operation, value, position, range) is taken at a clock edge
// where start is high and busy is low. Each request yields exactly one
// result, shown on result for one cycle with result_valid high; the
// receiver must take it in that cycle and cannot hold it off.
// Push, pop, insert, clear, and reversals that change nothing finish
// directly: the result appears the cycle after the request, and busy
// stays low, so such requests can follow every cycle.
// A reversal moves one element per cycle into the low end of its window
// while the rest of the window shifts up one cell; busy stays high until
// the window is done, and the result appears in the first cycle with
// busy low again.
// Reset clears the count and control state; element cells are not cleared
// and are only read once written.
// ----------------------------------------------------------------------------
module bounded_sequence_deque
    import bsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic result_valid,
    output rsp_t result
);

    cell_bus_t             cell_bus;
    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

    // Request decode, count and result.
    bsd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .cell_q       (cell_q),
        .cell_bus     (cell_bus),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // Row of element cells, each linked to its neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cell_bus.load_data;
        end
        else
        begin : g_left
            assign left_d = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_q[i];
        end
        else
        begin : g_right
            assign right_d = cell_q[i+1];
        end

        bsd_cell u_cell (
            .clk     (clk),
            .op      (cell_bus.op[i]),
            .left_d  (left_d),
            .right_d (right_d),
            .load_d  (cell_bus.load_data),
            .q       (cell_q[i])
        );
    end

endmodule
